[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/msd_pkg.sv]
package msd_pkg;

  // opcode patterns, matched against the top bits of the first byte
  localparam logic [5:0] OPC_REGMEM  = 6'b100010;
  localparam logic [3:0] OPC_IMM_REG = 4'b1011;
  localparam logic [6:0] OPC_IMM_MEM = 7'b1100011;
  localparam logic [5:0] OPC_ACC     = 6'b101000;

  // ModRM codes
  localparam logic [1:0] MOD_NONE   = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] RM_DIRECT  = 3'b110;

  // form codes on the result
  localparam logic [1:0] FORM_REGMEM  = 2'd0;
  localparam logic [1:0] FORM_IMM_REG = 2'd1;
  localparam logic [1:0] FORM_IMM_MEM = 2'd2;
  localparam logic [1:0] FORM_ACC     = 2'd3;

  // longest instruction and the bytes held before the last one arrives
  localparam int unsigned MAX_LEN     = 6;
  localparam int unsigned STORE_DEPTH = MAX_LEN - 1;

  typedef enum logic [2:0] {
    KIND_REGMEM,
    KIND_IMM_REG,
    KIND_IMM_MEM,
    KIND_ACC,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic [1:0]         form;
    logic               to_reg;
    logic               wide;
    logic [1:0]         mode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic [15:0]        value;
    logic [2:0]         length;
    logic               error;
  } res_t;

endpackage

[hdl/msd_decode.sv]
module msd_decode (
  input  logic [7:0]    bytes [msd_pkg::MAX_LEN],
  input  logic [2:0]    count,
  output logic [2:0]    len,
  output msd_pkg::res_t res
);

  logic [7:0]          b0, m;
  logic [1:0]          mod_f;
  logic [2:0]          rm_f;
  logic                direct;
  logic [1:0]          dbytes;
  logic [15:0]         disp;
  logic [15:0]         imm_mem;
  msd_pkg::kind_t      kind;

  assign b0     = bytes[0];
  assign m      = bytes[1];
  assign mod_f  = m[7:6];
  assign rm_f   = m[2:0];
  assign direct = (mod_f == msd_pkg::MOD_NONE) && (rm_f == msd_pkg::RM_DIRECT);

  // opcode class of the first byte
  always_comb begin
    if (b0[7:2] == msd_pkg::OPC_REGMEM)       kind = msd_pkg::KIND_REGMEM;
    else if (b0[7:4] == msd_pkg::OPC_IMM_REG) kind = msd_pkg::KIND_IMM_REG;
    else if (b0[7:1] == msd_pkg::OPC_IMM_MEM) kind = msd_pkg::KIND_IMM_MEM;
    else if (b0[7:2] == msd_pkg::OPC_ACC)     kind = msd_pkg::KIND_ACC;
    else                                      kind = msd_pkg::KIND_BAD;
  end

  // displacement bytes and the displacement itself
  always_comb begin
    case (mod_f)
      msd_pkg::MOD_NONE: begin
        dbytes = direct ? 2'd2 : 2'd0;
        disp   = direct ? {bytes[3], bytes[2]} : 16'h0000;
      end
      msd_pkg::MOD_DISP8: begin
        dbytes = 2'd1;
        disp   = {{8{bytes[2][7]}}, bytes[2]};
      end
      msd_pkg::MOD_DISP16: begin
        dbytes = 2'd2;
        disp   = {bytes[3], bytes[2]};
      end
      default: begin
        dbytes = 2'd0;
        disp   = 16'h0000;
      end
    endcase
  end

  // immediate of the imm-to-memory form sits after the displacement
  always_comb begin
    case (dbytes)
      2'd0:    imm_mem = b0[0] ? {bytes[3], bytes[2]} : {8'h00, bytes[2]};
      2'd1:    imm_mem = b0[0] ? {bytes[4], bytes[3]} : {8'h00, bytes[3]};
      default: imm_mem = b0[0] ? {bytes[5], bytes[4]} : {8'h00, bytes[4]};
    endcase
  end

  // length (zero while unknown) and result fields
  always_comb begin
    res = '0;
    len = 3'd1;
    case (kind)
      msd_pkg::KIND_REGMEM: begin
        len                = (count < 3'd2) ? 3'd0 : 3'd2 + {1'b0, dbytes};
        res.form           = msd_pkg::FORM_REGMEM;
        res.to_reg         = b0[1];
        res.wide           = b0[0];
        res.mode           = mod_f;
        res.reg_field      = m[5:3];
        res.rm_field       = rm_f;
        res.direct_address = direct;
        res.displacement   = direct ? 16'sh0000 : disp;
        res.value          = direct ? {bytes[3], bytes[2]} : 16'h0000;
      end
      msd_pkg::KIND_IMM_REG: begin
        len           = b0[3] ? 3'd3 : 3'd2;
        res.form      = msd_pkg::FORM_IMM_REG;
        res.to_reg    = 1'b1;
        res.wide      = b0[3];
        res.mode      = msd_pkg::MOD_REG;
        res.reg_field = b0[2:0];
        res.value     = b0[3] ? {bytes[2], bytes[1]} : {8'h00, bytes[1]};
      end
      msd_pkg::KIND_IMM_MEM: begin
        len = (count < 3'd2) ? 3'd0 : 3'd3 + {1'b0, dbytes} + {2'b00, b0[0]};
        res.form           = msd_pkg::FORM_IMM_MEM;
        res.wide           = b0[0];
        res.mode           = mod_f;
        res.reg_field      = m[5:3];
        res.rm_field       = rm_f;
        res.direct_address = direct;
        res.displacement   = disp;
        res.value          = imm_mem;
      end
      msd_pkg::KIND_ACC: begin
        len                = 3'd3;
        res.form           = msd_pkg::FORM_ACC;
        res.to_reg         = ~b0[1];
        res.wide           = b0[0];
        res.rm_field       = msd_pkg::RM_DIRECT;
        res.direct_address = 1'b1;
        res.value          = {bytes[2], bytes[1]};
      end
      default: begin
        res.error = 1'b1;
      end
    endcase
    res.length = len;
  end

endmodule

[hdl/mov_instruction_stream_decoder_top.sv]
// 16-bit MOV decoder: takes one code byte per cycle while in_stall is low and,
// once the last byte of an instruction is taken, registers and presents one
// decoded word on the out_ channel (1 to 6 bytes per instruction, unknown first
// bytes give an error word of length 1 and decoding restarts at the next byte).
// Decode is a single pass of field extraction between the byte store and the
// output register, so the sustained rate is one byte per cycle while in_stall
// is low. A one-entry skid stage behind the output register means in_stall only
// rises once a finished result finds the output register held by out_stall.
module mov_instruction_stream_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_form,
  output logic               out_to_reg,
  output logic               out_wide,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic               out_direct_address,
  output logic signed [15:0] out_displacement,
  output logic [15:0]        out_value,
  output logic [2:0]         out_length,
  output logic               out_error
);

  logic [7:0]    store_r [msd_pkg::STORE_DEPTH];
  logic [7:0]    view    [msd_pkg::MAX_LEN];
  logic [2:0]    held_r, held_nxt;
  logic [2:0]    count;
  logic [2:0]    len;
  logic          in_fire, done, out_take;
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  msd_pkg::res_t dec_res;
  msd_pkg::res_t out_res_r, skid_res_r;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign count    = held_r + 3'd1;

  // bytes seen so far, with the incoming byte dropped into its slot
  for (genvar i = 0; i < msd_pkg::STORE_DEPTH; i++) begin : g_view
    assign view[i] = (held_r == 3'(i)) ? in_code_byte : store_r[i];
  end
  assign view[msd_pkg::MAX_LEN-1] = in_code_byte;

  msd_decode u_decode (
    .bytes (view),
    .count (count),
    .len   (len),
    .res   (dec_res)
  );

  assign done = in_fire && (len != 3'd0) && (count == len);

  // byte counter and output/skid occupancy
  always_comb begin
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (in_fire) begin
      held_nxt = done ? 3'd0 : count;
    end
    if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (done) begin
      if (out_valid_r && !out_take) begin
        skid_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 3'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // byte store and result payloads
  always_ff @(posedge clk) begin
    if (in_fire && (held_r < 3'(msd_pkg::STORE_DEPTH))) begin
      store_r[held_r] <= in_code_byte;
    end
    if (skid_valid_r) begin
      if (out_take) begin
        out_res_r <= skid_res_r;
      end
    end else if (done) begin
      if (out_valid_r && !out_take) begin
        skid_res_r <= dec_res;
      end else begin
        out_res_r <= dec_res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_form           = out_res_r.form;
  assign out_to_reg         = out_res_r.to_reg;
  assign out_wide           = out_res_r.wide;
  assign out_mode           = out_res_r.mode;
  assign out_reg_field      = out_res_r.reg_field;
  assign out_rm_field       = out_res_r.rm_field;
  assign out_direct_address = out_res_r.direct_address;
  assign out_displacement   = out_res_r.displacement;
  assign out_value          = out_res_r.value;
  assign out_length         = out_res_r.length;
  assign out_error          = out_res_r.error;

endmodule

[hdl/msd_checker.sv]
`include "assert_macros.svh"

module msd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_form,
  input logic        out_direct_address,
  input logic [15:0] out_value,
  input logic [2:0]  out_length,
  input logic        out_error
);

  // held result word does not move
  `ASSERT_CLK(a_hold, out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_length), "result changed while stalled")

  // reset empties the output
  `ASSERT_CLK_RST(a_rst, !rst_n |=> !out_valid, "result shown after reset")

  // every instruction is one to six bytes
  `ASSERT_CLK(a_len, out_valid |-> out_length >= 3'd1 && out_length <= 3'd6, "length out of range")

  // error words are single bytes with the form cleared
  `ASSERT_CLK(a_err, out_valid && out_error |-> out_length == 3'd1 && out_form == msd_pkg::FORM_REGMEM, "bad error word")

  // accumulator moves always carry a direct address and three bytes
  `ASSERT_CLK(a_acc, out_valid && !out_error && out_form == msd_pkg::FORM_ACC |-> out_length == 3'd3 && out_direct_address, "bad accumulator word")

endmodule

bind mov_instruction_stream_decoder_top msd_checker u_checker (.*);

[tb/mov_instruction_stream_decoder_top_tb.sv]
`timescale 1ns / 1ps

module mov_instruction_stream_decoder_top_tb;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned PHASE_BYTES  = 240;

  typedef bit [7:0] code_seq_t [];

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_code_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_form;
  logic               out_to_reg;
  logic               out_wide;
  logic [1:0]         out_mode;
  logic [2:0]         out_reg_field;
  logic [2:0]         out_rm_field;
  logic               out_direct_address;
  logic signed [15:0] out_displacement;
  logic [15:0]        out_value;
  logic [2:0]         out_length;
  logic               out_error;

  // bytes of the instruction being gathered, and decoded words still to arrive
  bit [7:0]      gathered_bytes [$];
  msd_pkg::res_t expected_words [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requested = 0;
  int unsigned hold_granted   = 0;
  int unsigned hold_left      = 0;

  int unsigned bytes_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned error_words   = 0;
  int unsigned mismatches    = 0;

  mov_instruction_stream_decoder_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_code_byte       (in_code_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_form           (out_form),
    .out_to_reg         (out_to_reg),
    .out_wide           (out_wide),
    .out_mode           (out_mode),
    .out_reg_field      (out_reg_field),
    .out_rm_field       (out_rm_field),
    .out_direct_address (out_direct_address),
    .out_displacement   (out_displacement),
    .out_value          (out_value),
    .out_length         (out_length),
    .out_error          (out_error)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------

  function automatic msd_pkg::kind_t opcode_kind(bit [7:0] op);
    if (op[7:2] == msd_pkg::OPC_REGMEM)  return msd_pkg::KIND_REGMEM;
    if (op[7:4] == msd_pkg::OPC_IMM_REG) return msd_pkg::KIND_IMM_REG;
    if (op[7:1] == msd_pkg::OPC_IMM_MEM) return msd_pkg::KIND_IMM_MEM;
    if (op[7:2] == msd_pkg::OPC_ACC)     return msd_pkg::KIND_ACC;
    return msd_pkg::KIND_BAD;
  endfunction

  function automatic bit has_modrm(msd_pkg::kind_t k);
    return (k == msd_pkg::KIND_REGMEM) || (k == msd_pkg::KIND_IMM_MEM);
  endfunction

  function automatic bit is_direct(bit [7:0] modrm);
    return (modrm[7:6] == msd_pkg::MOD_NONE) && (modrm[2:0] == msd_pkg::RM_DIRECT);
  endfunction

  function automatic int unsigned disp_bytes_of(bit [7:0] modrm);
    case (modrm[7:6])
      msd_pkg::MOD_NONE:   return is_direct(modrm) ? 2 : 0;
      msd_pkg::MOD_DISP8:  return 1;
      msd_pkg::MOD_DISP16: return 2;
      default:             return 0;
    endcase
  endfunction

  // full instruction length; modrm is ignored by forms without one
  function automatic int unsigned instr_bytes(bit [7:0] op, bit [7:0] modrm);
    case (opcode_kind(op))
      msd_pkg::KIND_REGMEM:  return 2 + disp_bytes_of(modrm);
      msd_pkg::KIND_IMM_REG: return op[3] ? 3 : 2;
      msd_pkg::KIND_IMM_MEM: return 3 + disp_bytes_of(modrm) + op[0];
      msd_pkg::KIND_ACC:     return 3;
      default:               return 1;
    endcase
  endfunction

  // decoded word for the complete instruction in gathered_bytes
  function automatic msd_pkg::res_t decode_gathered();
    msd_pkg::res_t  r;
    msd_pkg::kind_t k;
    bit [7:0]       g [$];
    bit [7:0]       m;
    bit [15:0]      disp;
    int unsigned    at;
    g = gathered_bytes;
    k = opcode_kind(g[0]);
    r = '0;
    r.length = 3'(g.size());
    case (k)
      msd_pkg::KIND_BAD: r.error = 1'b1;
      msd_pkg::KIND_REGMEM, msd_pkg::KIND_IMM_MEM: begin
        m = g[1];
        r.form           = (k == msd_pkg::KIND_REGMEM) ? msd_pkg::FORM_REGMEM
                                                       : msd_pkg::FORM_IMM_MEM;
        r.wide           = g[0][0];
        r.mode           = m[7:6];
        r.reg_field      = m[5:3];
        r.rm_field       = m[2:0];
        r.direct_address = is_direct(m);
        if (m[7:6] == msd_pkg::MOD_DISP8)
          disp = {{8{g[2][7]}}, g[2]};
        else if (m[7:6] == msd_pkg::MOD_DISP16 || is_direct(m))
          disp = {g[3], g[2]};
        else
          disp = 16'h0000;
        if (k == msd_pkg::KIND_REGMEM) begin
          r.to_reg = g[0][1];
          // a direct address goes in value, not in displacement
          if (is_direct(m)) r.value = disp;
          else r.displacement = disp;
        end else begin
          r.displacement = disp;
          at = 2 + disp_bytes_of(m);
          r.value = g[0][0] ? {g[at + 1], g[at]} : {8'h00, g[at]};
        end
      end
      msd_pkg::KIND_IMM_REG: begin
        r.form      = msd_pkg::FORM_IMM_REG;
        r.to_reg    = 1'b1;
        r.wide      = g[0][3];
        r.mode      = msd_pkg::MOD_REG;
        r.reg_field = g[0][2:0];
        r.value     = g[0][3] ? {g[2], g[1]} : {8'h00, g[1]};
      end
      default: begin
        // accumulator: bit 1 clear is a load from memory
        r.form           = msd_pkg::FORM_ACC;
        r.to_reg         = ~g[0][1];
        r.wide           = g[0][0];
        r.rm_field       = msd_pkg::RM_DIRECT;
        r.direct_address = 1'b1;
        r.value          = {g[2], g[1]};
      end
    endcase
    return r;
  endfunction

  // take one accepted byte; queue a decoded word once the instruction is whole
  task automatic gather_code_byte(bit [7:0] b);
    msd_pkg::kind_t k;
    bit [7:0]       modrm;
    gathered_bytes.push_back(b);
    k = opcode_kind(gathered_bytes[0]);
    modrm = 8'h00;
    if (has_modrm(k)) begin
      if (gathered_bytes.size() < 2) return;
      modrm = gathered_bytes[1];
    end
    if (gathered_bytes.size() < instr_bytes(gathered_bytes[0], modrm)) return;
    expected_words.push_back(decode_gathered());
    gathered_bytes.delete();
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got 0x%h, want 0x%h",
                                words_checked, name, got, want));
  endtask

  task automatic check_word();
    msd_pkg::res_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected (value 0x%h, length %0d)",
                                out_value, out_length));
      return;
    end
    want = expected_words.pop_front();
    check_field("form",           16'(out_form),           16'(want.form));
    check_field("to_reg",         16'(out_to_reg),         16'(want.to_reg));
    check_field("wide",           16'(out_wide),           16'(want.wide));
    check_field("mode",           16'(out_mode),           16'(want.mode));
    check_field("reg_field",      16'(out_reg_field),      16'(want.reg_field));
    check_field("rm_field",       16'(out_rm_field),       16'(want.rm_field));
    check_field("direct_address", 16'(out_direct_address), 16'(want.direct_address));
    check_field("displacement",   out_displacement,        want.displacement);
    check_field("value",          out_value,               want.value);
    check_field("length",         16'(out_length),         16'(want.length));
    check_field("error",          16'(out_error),          16'(want.error));
    if (want.error) error_words++;
    words_checked++;
  endtask

  // receiver: random stalls, long hold-offs on request, and the word check
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requested != hold_granted) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      hold_granted <= hold_granted + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
    if (rst_n) begin
      if ($isunknown(out_valid))
        report_mismatch("out_valid unknown after reset");
      else if (out_valid && !out_stall)
        check_word();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  // offer one byte, with a random gap first, and hold it until taken
  task automatic send_byte(bit [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_code_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    gather_code_byte(b);
  endtask

  task automatic send_bytes(code_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // sender goes quiet until every decoded word is in
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed instructions with random content, some stray bytes
  task automatic send_random_instr();
    bit [7:0]    op;
    bit [7:0]    modrm;
    int unsigned n;
    int unsigned sent;
    if ($urandom_range(99) < 10) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(3))
      0:       op = {msd_pkg::OPC_REGMEM, 2'($urandom_range(3))};
      1:       op = {msd_pkg::OPC_IMM_REG, 4'($urandom_range(15))};
      2:       op = {msd_pkg::OPC_IMM_MEM, 1'($urandom_range(1))};
      default: op = {msd_pkg::OPC_ACC, 2'($urandom_range(3))};
    endcase
    modrm = 8'($urandom_range(255));
    if ($urandom_range(3) == 0)
      modrm = {msd_pkg::MOD_NONE, modrm[5:3], msd_pkg::RM_DIRECT};
    n = instr_bytes(op, modrm);
    send_byte(op);
    sent = 1;
    if (has_modrm(opcode_kind(op))) begin
      send_byte(modrm);
      sent = 2;
    end
    for (int unsigned i = sent; i < n; i++) send_byte(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_unknown_opcodes();
    send_bytes('{8'h00, 8'hFF});
  endtask

  task automatic test_regmem_forms();
    send_bytes('{{msd_pkg::OPC_REGMEM, 2'b11}, {msd_pkg::MOD_REG, 3'd7, 3'd0}});
    // negative disp8 must sign-extend
    send_bytes('{{msd_pkg::OPC_REGMEM, 2'b01}, {msd_pkg::MOD_DISP8, 3'd0, 3'd6},
                 8'h80});
    send_bytes('{{msd_pkg::OPC_REGMEM, 2'b10},
                 {msd_pkg::MOD_NONE, 3'd5, msd_pkg::RM_DIRECT}, 8'h34, 8'h12});
  endtask

  task automatic test_imm_forms();
    send_bytes('{{msd_pkg::OPC_IMM_REG, 1'b0, 3'd7}, 8'hFF});
    send_bytes('{{msd_pkg::OPC_IMM_REG, 1'b1, 3'd0}, 8'hFF, 8'hFF});
    // longest instruction: word immediate to a direct address
    send_bytes('{{msd_pkg::OPC_IMM_MEM, 1'b1},
                 {msd_pkg::MOD_NONE, 3'd0, msd_pkg::RM_DIRECT},
                 8'h00, 8'h80, 8'hCD, 8'hAB});
    send_bytes('{{msd_pkg::OPC_IMM_MEM, 1'b0}, {msd_pkg::MOD_REG, 3'd7, 3'd3}, 8'h7F});
  endtask

  task automatic test_acc_forms();
    send_bytes('{{msd_pkg::OPC_ACC, 2'b01}, 8'h00, 8'h80});
    send_bytes('{{msd_pkg::OPC_ACC, 2'b10}, 8'hFF, 8'hFF});
  endtask

  task automatic test_random_stream(int unsigned send_pct, int unsigned recv_pct,
                                    int unsigned n);
    int unsigned start;
    set_idling(send_pct, recv_pct);
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_instr();
    wait_results();
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_output_hold_off();
    int unsigned start;
    set_idling(0, 0);
    hold_requested <= hold_requested + 1;
    start = bytes_sent;
    while (bytes_sent - start < 60) send_random_instr();
    wait_results();
  endtask

  // ---------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_unknown_opcodes();
    test_regmem_forms();
    test_imm_forms();
    test_acc_forms();
    wait_results();

    test_random_stream(0, 0, PHASE_BYTES);
    test_random_stream(81, 0, PHASE_BYTES);
    test_random_stream(0, 81, PHASE_BYTES);
    test_random_stream(13, 13, PHASE_BYTES);
    test_output_hold_off();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d code bytes decoded into %0d words (%0d error words),",
             bytes_sent, words_checked, error_words);
    $display("all four move forms, four idling mixes and a long output hold-off.");
    if (mismatches == 0) begin
      $display("** mov_instruction_stream_decoder_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** mov_instruction_stream_decoder_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d words outstanding", expected_words.size());
    $display("** mov_instruction_stream_decoder_top: FAILED **");
    $finish;
  end

endmodule

[mov_instruction_stream_decoder_top.f]
+incdir+hdl
hdl/msd_pkg.sv
hdl/msd_decode.sv
hdl/mov_instruction_stream_decoder_top.sv
hdl/msd_checker.sv
tb/mov_instruction_stream_decoder_top_tb.sv
